@@ design/assert_macros.svh @@
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ design/ftsa_pkg.sv @@
package ftsa_pkg;

  // field widths
  localparam int STEP_W    = 17;
  localparam int ZOOM_W    = 3;
  localparam int DET_W     = 4;
  localparam int TIME_W    = 32;
  localparam int FREQ_W    = 31;
  localparam int OFS_W     = 32;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = STEP_W + 1 + DET_W;
  localparam int SUM_W     = OFS_W + 2;

  // packed stream widths, padded to whole bytes
  localparam int IN_W       = DET_W + TIME_W + FREQ_W;
  localparam int IN_BUS_W   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = OFS_W + OFS_W + 3;
  localparam int OUT_BUS_W  = ((OUT_W + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_EN   = 2'd3;

  // reset values and tuning constants
  localparam logic [STEP_W-1:0] FINE_STEP_RST = 17'd50;
  localparam logic [STEP_W-1:0] FAST_STEP_HZ  = 17'd1000;
  localparam logic [CNT_W-1:0]  TRIGGER_COUNT = 3'd4;
  localparam logic [CNT_W-1:0]  CNT_MAX       = 3'd7;
  localparam logic [TIME_W-1:0] SHORT_GAP_MS  = 32'd100;
  localparam logic [TIME_W-1:0] CANCEL_GAP_MS = 32'd500;

  // recentring window limits
  localparam logic signed [OFS_W-1:0] WIN0_HI     = 32'sd142000;
  localparam logic signed [OFS_W-1:0] WIN0_LO     = -32'sd43000;
  localparam logic [OFS_W-1:0]        WIN_HI_BASE = 32'd95000;
  localparam logic [OFS_W-1:0]        WIN_LO_BASE = 32'd93000;

  localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
  localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

  typedef struct packed {
    logic [STEP_W-1:0] fine_step;
    logic [ZOOM_W-1:0] zoom;
    logic              cal_mode;
    logic              fast_enable;
  } cfg_t;

  typedef struct packed {
    logic fast_on;
    logic fast_next;
  } accel_t;

  // offset outside the window for this zoom
  function automatic logic outside_window(input logic signed [OFS_W-1:0] off,
                                          input logic [ZOOM_W-1:0] zoom);
    logic signed [OFS_W-1:0] hi;
    logic signed [OFS_W-1:0] lo;
    hi = $signed(WIN_HI_BASE >> zoom);
    lo = -$signed(WIN_LO_BASE >> zoom);
    if (zoom == '0) begin
      return (off > WIN0_HI) || (off < WIN0_LO);
    end
    return (off >= hi) || (off < lo);
  endfunction

endpackage

@@ design/ftsa_cfg.sv @@
module ftsa_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ftsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftsa_pkg::STEP_W-1:0]    cfg_wdata,
  output ftsa_pkg::cfg_t                 cfg
);
  import ftsa_pkg::*;

  // register file, written one register per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fine_step   <= FINE_STEP_RST;
      cfg.zoom        <= '0;
      cfg.cal_mode    <= 1'b0;
      cfg.fast_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FINE_STEP: cfg.fine_step   <= cfg_wdata;
        REG_ZOOM:      cfg.zoom        <= cfg_wdata[ZOOM_W-1:0];
        REG_CAL:       cfg.cal_mode    <= cfg_wdata[0];
        REG_FAST_EN:   cfg.fast_enable <= cfg_wdata[0];
        default:       cfg.cal_mode    <= cfg.cal_mode;
      endcase
    end
  end

endmodule

@@ design/ftsa_accel.sv @@
`include "assert_macros.svh"

module ftsa_accel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        move,
  input  logic [ftsa_pkg::TIME_W-1:0] now_ms,
  input  ftsa_pkg::cfg_t              cfg,
  output ftsa_pkg::accel_t            accel
);
  import ftsa_pkg::*;

  logic              fast_on;
  logic              fast_on_next;
  logic [CNT_W-1:0]  short_gap_count;
  logic [CNT_W-1:0]  short_gap_count_next;
  logic [CNT_W-1:0]  cnt_inc;
  logic [TIME_W-1:0] last_move_time;
  logic [TIME_W-1:0] gap;

  // gap since the last move, wrapping
  assign gap = now_ms - last_move_time;

  // short gap counting and fast mode entry and exit
  always_comb begin
    cnt_inc = short_gap_count;
    if ((gap <= SHORT_GAP_MS) && (short_gap_count < CNT_MAX)) begin
      cnt_inc = short_gap_count + 3'd1;
    end
    fast_on_next         = fast_on;
    short_gap_count_next = short_gap_count;
    priority if (!cfg.fast_enable) begin
      fast_on_next         = 1'b0;
      short_gap_count_next = '0;
    end else if (fast_on) begin
      fast_on_next = (gap < CANCEL_GAP_MS);
    end else if (cnt_inc >= TRIGGER_COUNT) begin
      fast_on_next         = 1'b1;
      short_gap_count_next = '0;
    end else begin
      short_gap_count_next = cnt_inc;
    end
  end

  assign accel.fast_on   = fast_on;
  assign accel.fast_next = fast_on_next;

  // state advances only on a taken move
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_on         <= 1'b0;
      short_gap_count <= '0;
      last_move_time  <= '0;
    end else if (move) begin
      fast_on         <= fast_on_next;
      short_gap_count <= short_gap_count_next;
      last_move_time  <= now_ms;
    end
  end

  `ASSERT_ALWAYS(a_cnt_below_trigger, clk, rst, short_gap_count < TRIGGER_COUNT)
  `ASSERT_IMPL(a_fast_cnt_clear, clk, rst, fast_on, short_gap_count == '0)

endmodule

@@ design/ftsa_offset.sv @@
`include "assert_macros.svh"

module ftsa_offset (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic                               apply,
  input  logic                               fast_sel,
  input  ftsa_pkg::cfg_t                     cfg,
  input  logic signed [ftsa_pkg::DET_W-1:0]  detents,
  input  logic [ftsa_pkg::FREQ_W-1:0]        center_freq,
  output logic signed [ftsa_pkg::OFS_W-1:0]  offset_hz,
  output logic signed [ftsa_pkg::OFS_W-1:0]  tuned_freq,
  output logic                               recenter_request
);
  import ftsa_pkg::*;

  logic signed [OFS_W-1:0]  tune_offset;
  logic signed [OFS_W-1:0]  tune_offset_next;
  logic [STEP_W-1:0]        step;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] delta;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  tuned_raw;
  logic                     ofs_hi;
  logic                     ofs_lo;
  logic                     tun_hi;
  logic                     tun_lo;

  // step times detents, zero when the item is not applied
  assign step  = fast_sel ? FAST_STEP_HZ : cfg.fine_step;
  assign prod  = $signed({1'b0, step}) * detents;
  assign delta = apply ? prod : '0;

  // new offset and center plus offset in one three-input add
  assign sum       = {{2{tune_offset[OFS_W-1]}}, tune_offset}
                   + {{(SUM_W-PROD_W){delta[PROD_W-1]}}, delta};
  assign tuned_raw = sum + {{(SUM_W-FREQ_W){1'b0}}, center_freq};

  // saturation, a clamped low offset leaves center minus 2^31 in range
  always_comb begin
    ofs_hi = !sum[SUM_W-1] && (sum[SUM_W-2:OFS_W-1] != '0);
    ofs_lo = sum[SUM_W-1] && (sum[SUM_W-2:OFS_W-1] != '1);
    tun_hi = !tuned_raw[SUM_W-1] && (tuned_raw[SUM_W-2:OFS_W-1] != '0);
    tun_lo = tuned_raw[SUM_W-1] && (tuned_raw[SUM_W-2:OFS_W-1] != '1);
    priority if (ofs_hi) begin
      tune_offset_next = OFS_MAX;
      tuned_freq       = OFS_MAX;
    end else if (ofs_lo) begin
      tune_offset_next = OFS_MIN;
      tuned_freq       = {1'b1, center_freq};
    end else begin
      tune_offset_next = sum[OFS_W-1:0];
      if (tun_hi) begin
        tuned_freq = OFS_MAX;
      end else if (tun_lo) begin
        tuned_freq = OFS_MIN;
      end else begin
        tuned_freq = tuned_raw[OFS_W-1:0];
      end
    end
  end

  assign offset_hz        = tune_offset_next;
  assign recenter_request = apply && outside_window(tune_offset_next, cfg.zoom);

  // accumulated offset
  always_ff @(posedge clk) begin
    if (rst) begin
      tune_offset <= '0;
    end else if (fire && apply) begin
      tune_offset <= tune_offset_next;
    end
  end

  `ASSERT_NEXT(a_offset_holds, clk, rst, !(fire && apply), $stable(tune_offset))

endmodule

@@ design/fine_tune_step_accelerator.sv @@
// Fine tune step accelerator: each input transaction carries encoder detents, a millisecond
// timestamp and the center frequency, and yields exactly one result transaction with the
// accumulated offset, center plus offset (both saturated to 32 bits signed), a recenter
// request, the fast mode flag and whether the move was taken. One item is accepted every
// clock cycle when the output side keeps up. Each accepted item passes through the input
// register and then the result register, around a single pass of gap compare, step
// multiply and saturating add. The user must write configuration registers through the
// plain write port only while no transaction is in flight; the block does not enforce it.
`include "assert_macros.svh"

module fine_tune_step_accelerator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ftsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftsa_pkg::STEP_W-1:0]       cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // step_count[3:0], now_ms[35:4], center_freq[66:36], zero pad
  input  logic [ftsa_pkg::IN_BUS_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // offset_hz[31:0], tuned_freq[63:32], recenter_request[64], fast_mode[65],
  // applied[66], zero pad
  output logic [ftsa_pkg::OUT_BUS_W-1:0]    m_tdata
);
  import ftsa_pkg::*;

  cfg_t                    cfg;
  accel_t                  accel;
  logic                    in_vld;
  logic [IN_W-1:0]         in_data;
  logic                    out_vld;
  logic [OUT_W-1:0]        out_data;
  logic                    fire;
  logic                    apply;
  logic                    move;
  logic signed [DET_W-1:0] detents;
  logic [TIME_W-1:0]       now_ms;
  logic [FREQ_W-1:0]       center_freq;
  logic signed [OFS_W-1:0] offset_hz;
  logic signed [OFS_W-1:0] tuned_freq;
  logic                    recenter_request;
  logic                    fast_mode;

  ftsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register unpacking
  assign detents     = in_data[DET_W-1:0];
  assign now_ms      = in_data[DET_W+TIME_W-1:DET_W];
  assign center_freq = in_data[IN_W-1:DET_W+TIME_W];

  // handshake: item in the input register moves on when the result slot frees
  assign fire     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || fire;
  assign apply    = (detents != '0) && !cfg.cal_mode;
  assign move     = fire && apply;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata[IN_W-1:0];
    end
  end

  ftsa_accel u_accel (
    .clk    (clk),
    .rst    (rst),
    .move   (move),
    .now_ms (now_ms),
    .cfg    (cfg),
    .accel  (accel)
  );

  ftsa_offset u_offset (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .apply            (apply),
    .fast_sel         (accel.fast_next),
    .cfg              (cfg),
    .detents          (detents),
    .center_freq      (center_freq),
    .offset_hz        (offset_hz),
    .tuned_freq       (tuned_freq),
    .recenter_request (recenter_request)
  );

  assign fast_mode = apply ? accel.fast_next : accel.fast_on;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {apply, fast_mode, recenter_request, tuned_freq, offset_hz};
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {{(OUT_BUS_W-OUT_W){1'b0}}, out_data};

  `ASSERT_IMPL(a_recenter_needs_move, clk, rst, m_tvalid && out_data[OUT_W-3], out_data[OUT_W-1])

endmodule
